// ===== rtl/core/sha256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    // Eight 32-bit words, index 0 is word a / H0
    typedef logic [7:0][31:0] t_words;

    // Command bundle from the byte sequencer to the compression core
    typedef struct packed {
        logic        load;   // shift one message word into the schedule window
        logic        start;  // begin the 64 rounds on the loaded block
        logic        init;   // return the chaining value to the initial hash
        logic [31:0] word;
    } t_core_cmd;

    localparam t_words C_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] C_PAD_MARK = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'd56;
    localparam logic [5:0] C_LAST_POS = 6'd63;
    localparam logic [5:0] C_LAST_RND = 6'd63;
    localparam logic [2:0] C_LAST_IDX = 3'd7;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        f_rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        f_bsig0 = f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        f_bsig1 = f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        f_ssig0 = f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        f_ssig1 = f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constants
    function automatic logic [31:0] f_k(input logic [5:0] i);
        unique case (i)
            6'd0:  f_k = 32'h428a2f98;  6'd1:  f_k = 32'h71374491;
            6'd2:  f_k = 32'hb5c0fbcf;  6'd3:  f_k = 32'he9b5dba5;
            6'd4:  f_k = 32'h3956c25b;  6'd5:  f_k = 32'h59f111f1;
            6'd6:  f_k = 32'h923f82a4;  6'd7:  f_k = 32'hab1c5ed5;
            6'd8:  f_k = 32'hd807aa98;  6'd9:  f_k = 32'h12835b01;
            6'd10: f_k = 32'h243185be;  6'd11: f_k = 32'h550c7dc3;
            6'd12: f_k = 32'h72be5d74;  6'd13: f_k = 32'h80deb1fe;
            6'd14: f_k = 32'h9bdc06a7;  6'd15: f_k = 32'hc19bf174;
            6'd16: f_k = 32'he49b69c1;  6'd17: f_k = 32'hefbe4786;
            6'd18: f_k = 32'h0fc19dc6;  6'd19: f_k = 32'h240ca1cc;
            6'd20: f_k = 32'h2de92c6f;  6'd21: f_k = 32'h4a7484aa;
            6'd22: f_k = 32'h5cb0a9dc;  6'd23: f_k = 32'h76f988da;
            6'd24: f_k = 32'h983e5152;  6'd25: f_k = 32'ha831c66d;
            6'd26: f_k = 32'hb00327c8;  6'd27: f_k = 32'hbf597fc7;
            6'd28: f_k = 32'hc6e00bf3;  6'd29: f_k = 32'hd5a79147;
            6'd30: f_k = 32'h06ca6351;  6'd31: f_k = 32'h14292967;
            6'd32: f_k = 32'h27b70a85;  6'd33: f_k = 32'h2e1b2138;
            6'd34: f_k = 32'h4d2c6dfc;  6'd35: f_k = 32'h53380d13;
            6'd36: f_k = 32'h650a7354;  6'd37: f_k = 32'h766a0abb;
            6'd38: f_k = 32'h81c2c92e;  6'd39: f_k = 32'h92722c85;
            6'd40: f_k = 32'ha2bfe8a1;  6'd41: f_k = 32'ha81a664b;
            6'd42: f_k = 32'hc24b8b70;  6'd43: f_k = 32'hc76c51a3;
            6'd44: f_k = 32'hd192e819;  6'd45: f_k = 32'hd6990624;
            6'd46: f_k = 32'hf40e3585;  6'd47: f_k = 32'h106aa070;
            6'd48: f_k = 32'h19a4c116;  6'd49: f_k = 32'h1e376c08;
            6'd50: f_k = 32'h2748774c;  6'd51: f_k = 32'h34b0bcb5;
            6'd52: f_k = 32'h391c0cb3;  6'd53: f_k = 32'h4ed8aa4a;
            6'd54: f_k = 32'h5b9cca4f;  6'd55: f_k = 32'h682e6ff3;
            6'd56: f_k = 32'h748f82ee;  6'd57: f_k = 32'h78a5636f;
            6'd58: f_k = 32'h84c87814;  6'd59: f_k = 32'h8cc70208;
            6'd60: f_k = 32'h90befffa;  6'd61: f_k = 32'ha4506ceb;
            6'd62: f_k = 32'hbef9a3f7;  6'd63: f_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
`timescale 1ns / 1ps
`default_nettype none

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, output digest_word, output word_index,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input final_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: byte packing, padding and digest output.
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 over a byte stream. Each input word carries at most one message byte
// and may close the message. Bytes are taken one per cycle while a block fills;
// the 64th byte of a block starts the compression core, which runs one round per
// cycle, and input stalls until the new chaining value is folded in.
// Closing a message makes the block insert 0x80, zeros and the 64-bit bit length
// itself, one byte per cycle through the same path (up to 72 bytes and two
// compressions), and then present the eight digest words, H0 first, with
// final_word set on the last. Input is not ready until the eighth word is taken;
// the hash then restarts from the initial value.

module sha256_stream_hasher_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     i_byte,
    sha256_out_if.source  o_digest
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COMP = 4'b0010,
        S_PAD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_state      r_after, n_after;
    logic [5:0]  r_fill,  n_fill;
    logic [23:0] r_word,  n_word;
    logic [63:0] r_bits,  n_bits;
    logic        r_mark,  n_mark;
    logic        r_len_ok, n_len_ok;
    logic [2:0]  r_idx,   n_idx;

    logic        w_in_acc, w_out_acc, w_pad, w_push, w_len_phase, w_wrap;
    logic [7:0]  w_pad_byte, w_push_byte;
    t_core_cmd   w_cmd;
    logic        w_done;
    t_words      w_hash;

    // Handshakes
    assign i_byte.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_byte.valid && i_byte.ready;
    assign w_out_acc    = o_digest.valid && o_digest.ready;

    // Padding byte: marker, then zeros, then the length from the top byte down
    assign w_pad       = (r_state == S_PAD);
    assign w_len_phase = r_len_ok && (r_fill >= C_LEN_POS);
    assign w_pad_byte  = !r_mark ? C_PAD_MARK : (w_len_phase ? r_bits[63:56] : 8'h00);

    assign w_push      = (w_in_acc && i_byte.byte_present) || w_pad;
    assign w_push_byte = w_pad ? w_pad_byte : i_byte.data_byte;
    assign w_wrap      = w_push && (r_fill == C_LAST_POS);

    // Core commands
    always_comb begin
        w_cmd.load  = w_push && (r_fill[1:0] == 2'b11);
        w_cmd.start = w_wrap;
        w_cmd.init  = w_out_acc && (r_idx == C_LAST_IDX);
        w_cmd.word  = {r_word, w_push_byte};
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_fill   = r_fill;
        n_word   = r_word;
        n_bits   = r_bits;
        n_mark   = r_mark;
        n_len_ok = r_len_ok;
        n_idx    = r_idx;

        if (w_push) begin
            n_fill = r_fill + 6'd1;
            n_word = {r_word[15:0], w_push_byte};
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_byte.byte_present) begin
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_byte.end_of_message) begin
                        n_mark   = 1'b0;
                        n_len_ok = 1'b0;
                    end
                    if (w_wrap) begin
                        n_state = S_COMP;
                        n_after = i_byte.end_of_message ? S_PAD : S_IDLE;
                    end else if (i_byte.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_mark = 1'b1;
                if (r_fill < C_LEN_POS) begin
                    n_len_ok = 1'b1;
                end
                if (w_len_phase) begin
                    n_bits = {r_bits[55:0], 8'h00};
                end
                if (w_wrap) begin
                    n_state = S_COMP;
                    n_after = w_len_phase ? S_OUT : S_PAD;
                end
            end
            S_COMP: begin
                if (w_done) begin
                    n_state = r_after;
                    n_idx   = '0;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == C_LAST_IDX) begin
                        n_state  = S_IDLE;
                        n_bits   = '0;
                        n_mark   = 1'b0;
                        n_len_ok = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_mark   <= 1'b0;
            r_len_ok <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_mark   <= n_mark;
            r_len_ok <= n_len_ok;
            r_idx    <= n_idx;
        end
    end

    // Partial word, message and padding bytes alike
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_done  (w_done),
        .o_hash  (w_hash)
    );

    // Digest output straight from the chaining registers
    assign o_digest.valid       = (r_state == S_OUT);
    assign o_digest.digest_word = w_hash[r_idx];
    assign o_digest.word_index  = r_idx;
    assign o_digest.final_word  = (r_idx == C_LAST_IDX);

endmodule

`default_nettype wire

// ===== rtl/core/sha256_core.sv =====
// SHA-256 compression core: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
`default_nettype none

module sha256_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_cmd i_cmd,
    output logic                  o_done,
    output sha256_pkg::t_words    o_hash
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_ROUND = 4'b0010,
        C_FOLD  = 4'b0100,
        C_DONE  = 4'b1000
    } t_cstate;

    t_cstate     r_state, n_state;
    logic [5:0]  r_rnd;
    logic [31:0] r_w [16];
    t_words      r_v;
    t_words      r_h;

    logic [31:0] w_t1, w_t2, w_sched, w_shift_in;
    logic [31:0] w_ch, w_maj;
    logic        w_shift;

    // Round datapath and next schedule word
    always_comb begin
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + f_bsig1(r_v[4]) + w_ch + f_k(r_rnd) + r_w[0];
        w_t2    = f_bsig0(r_v[0]) + w_maj;
        w_sched = r_w[0] + f_ssig0(r_w[1]) + r_w[9] + f_ssig1(r_w[14]);
    end

    assign w_shift    = (r_state == C_ROUND) || i_cmd.load;
    assign w_shift_in = (r_state == C_ROUND) ? w_sched : i_cmd.word;

    // Schedule window, oldest word at index 0
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j + 1];
            end
            r_w[15] <= w_shift_in;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_cmd.start) n_state = C_ROUND;
            C_ROUND: if (r_rnd == C_LAST_RND) n_state = C_FOLD;
            C_FOLD:  n_state = C_DONE;
            C_DONE:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= (r_state == C_ROUND) ? r_rnd + 6'd1 : '0;
        end
    end

    // Working variables and chaining value
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_cmd.start) begin
            r_v <= r_h;
        end else if (r_state == C_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_h <= C_IV;
        end else if (r_state == C_FOLD) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= r_h[j] + r_v[j];
            end
        end
    end

    assign o_done = (r_state == C_DONE);
    assign o_hash = r_h;

endmodule

`default_nettype wire

// ===== sim/sha256_stream_hasher_checker.sv =====
// Checker for the SHA-256 stream hasher: watches both channels, predicts digests, compares.
`timescale 1ns / 1ps

module sha256_stream_hasher_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sha256_in_if   i_byte,
    sha256_out_if  i_digest,
    output int     o_fail_count,
    output int     o_pending
);

    // Round constants, index 0 first
    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial chaining value, H0 first
    localparam logic [0:7][31:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_START = 56;
    localparam int         BLK_BYTES = 64;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    // Hash state of the model
    logic [31:0]  chain [8];
    logic [7:0]   blk [BLK_BYTES];
    int           fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_q [$];
    int           fails;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns  mismatch in %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    task automatic restart_hash();
        int i;
        for (i = 0; i < 8; i++) chain[i] = START_HASH[i];
        fill     = 0;
        msg_bits = '0;
    endtask

    // 64 rounds over blk, folded into chain
    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    // One accepted input word: absorb its byte, and on close pad and queue the digest
    task automatic absorb_word(input logic [7:0] data, input logic present, input logic close);
        digest_word_t dw;
        int i;
        if (present) begin
            blk[fill] = data;
            msg_bits += 64'd8;
            fill++;
            if (fill == BLK_BYTES) begin
                fold_block();
                fill = 0;
            end
        end
        if (close) begin
            blk[fill] = PAD_BYTE;
            fill++;
            // no room left for the length: pad out and spill into a second block
            if (fill > LEN_START) begin
                for (i = fill; i < BLK_BYTES; i++) blk[i] = '0;
                fold_block();
                fill = 0;
            end
            for (i = fill; i < LEN_START; i++) blk[i] = '0;
            for (i = 0; i < 8; i++) blk[LEN_START + i] = msg_bits[63 - 8*i -: 8];
            fold_block();
            for (i = 0; i < 8; i++) begin
                dw.word = chain[i];
                dw.idx  = 3'(i);
                dw.last = (i == 7);
                digest_q.push_back(dw);
            end
            restart_hash();
        end
    endtask

    // Sample both channels at each edge
    always @(posedge i_clk) begin
        digest_word_t want;
        if (!i_rst_n) begin
            restart_hash();
            for (int i = 0; i < BLK_BYTES; i++) blk[i] = '0;
            digest_q.delete();
        end else begin
            if (i_digest.valid === 1'b1 && i_digest.ready === 1'b1) begin
                if (digest_q.size() == 0) begin
                    report("unexpected digest word", i_digest.digest_word, 32'h0);
                end else begin
                    want = digest_q.pop_front();
                    if (i_digest.digest_word !== want.word)
                        report("digest_word", i_digest.digest_word, want.word);
                    if (i_digest.word_index !== want.idx)
                        report("word_index", 32'(i_digest.word_index), 32'(want.idx));
                    if (i_digest.final_word !== want.last)
                        report("final_word", 32'(i_digest.final_word), 32'(want.last));
                end
            end
            if (i_byte.valid === 1'b1 && i_byte.ready === 1'b1)
                absorb_word(i_byte.data_byte, i_byte.byte_present, i_byte.end_of_message);
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
    end

endmodule

// ===== sim/sha256_stream_hasher_top_tb.sv =====
// Testbench top for the SHA-256 stream hasher: clock, reset, byte stimulus, verdict.
`timescale 1ns / 1ps

module sha256_stream_hasher_top_tb;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   words_sent;

    sha256_in_if  byte_ch ();
    sha256_out_if digest_ch ();

    sha256_stream_hasher_top u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_ch),
        .o_digest (digest_ch)
    );

    sha256_stream_hasher_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte       (byte_ch),
        .i_digest     (digest_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("FAIL sha256_stream_hasher_top");
        $finish;
    end

    // Offer one word and hold it until taken; gaps fall between bursts
    task automatic send_word(input logic [7:0] data, input logic present, input logic close);
        int gap;
        byte_ch.data_byte      <= data;
        byte_ch.byte_present   <= present;
        byte_ch.end_of_message <= close;
        byte_ch.valid          <= 1'b1;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        if (present || close) words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
            // now and then a long run with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 15);
        end
    endtask

    // Digest receiver: mixed stall patterns, plus one long hold-off
    initial begin
        int          cyc;
        int          mode;
        int          hold_left;
        bit          held;
        logic [15:0] pat;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        held      = 1'b0;
        pat       = 16'hffff;
        digest_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                digest_ch.ready <= 1'b0;
            end else if (!held && cyc > 1000 && digest_ch.valid === 1'b1) begin
                // back the block up into its input while the sender keeps going
                held      = 1'b1;
                hold_left = 400;
                digest_ch.ready <= 1'b0;
            end else begin
                if (cyc % 64 == 0) begin
                    mode = $urandom_range(0, 2);
                    pat  = 16'($urandom);
                end
                case (mode)
                    0: digest_ch.ready <= 1'b1;
                    1: digest_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        digest_ch.ready <= pat[0];
                        pat = {pat[0], pat[15:1]};
                    end
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int len;
        int sel;
        int k;
        bit close_on_byte;
        int edge_lens [9];
        edge_lens = '{54, 55, 56, 57, 63, 64, 65, 119, 120};
        burst_left = 0;
        words_sent = 0;
        rst_n                  <= 1'b0;
        byte_ch.valid          <= 1'b0;
        byte_ch.data_byte      <= 8'h00;
        byte_ch.byte_present   <= 1'b0;
        byte_ch.end_of_message <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message closed by a word without a byte
        send_word(8'hff, 1'b0, 1'b1);
        // single zero byte, closed on the byte itself
        send_word(8'h00, 1'b1, 1'b1);
        // byte, empty word, then close without byte
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
        // "abc"
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // empty words change nothing: still the empty-string digest
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b1);

        // Random messages, lengths biased to the padding boundaries
        while (words_sent < 350) begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                len = $urandom_range(0, 20);
            else if (sel < 8)
                len = edge_lens[$urandom_range(0, 8)];
            else
                len = $urandom_range(100, 130);
            close_on_byte = 1'($urandom_range(0, 1));
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(8'($urandom), 1'b0, 1'b0);
                send_word(8'($urandom), 1'b1, close_on_byte && (k == len - 1));
            end
            if (!close_on_byte || len == 0)
                send_word(8'($urandom), 1'b0, 1'b1);
        end
        byte_ch.valid <= 1'b0;

        // drain, then watch a while for stray words
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS sha256_stream_hasher_top");
        end else begin
            $display("FAIL sha256_stream_hasher_top");
        end
        $finish;
    end

endmodule
